FILE: hdl/delimited_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_PACKET_DEFRAMER_DEFINES_SVH
`define DELIMITED_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define DPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: hdl/dpd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Tag lengths, result kinds, phase codes and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

  localparam int START_TAG_LEN = 4;
  localparam int END_TAG_LEN   = 4;
  localparam int LENGTH_BYTES  = 4;

  localparam logic [1:0] START_LAST  = 2'(START_TAG_LEN - 1);
  localparam logic [1:0] END_LAST    = 2'(END_TAG_LEN - 1);
  localparam logic [1:0] LENGTH_LAST = 2'(LENGTH_BYTES - 1);

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  localparam logic [0:0] REG_START_BYTE = 1'b0;
  localparam logic [0:0] REG_END_BYTE   = 1'b1;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_MODE   = 5'b00010,
    PH_LENGTH = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_END    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_mode;
    logic [31:0] packet_length;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/delimited_packet_deframer.sv
// ----------------------------------------------------------------------------
// Delimited packet deframer
// Parses start tag, mode, little-endian length, payload and end tag from a
// byte stream; emits payload beats and an accept or drop beat per packet.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  rx      | rx_valid  | rx_stall  | rx_byte
//  res     | res_valid | res_stall | kind, data_byte, frame_mode, packet_length
//
//  One byte per cycle while rx_stall is low: each accepted byte updates the parse
//  state in the same cycle and lands its result, if any, in the output register,
//  or in the skid register when the output register is held.
//  A one-entry skid register holds a result while res_stall is high;
//  rx_stall rises only when that skid entry is full.
//  rst is synchronous: return to the start-tag search, clear the valids, the
//  packet fields and both tag bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        rx_valid,
  output logic             rx_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [7:0]       frame_mode,
  output logic [31:0]      packet_length
);

  import dpd_pkg::*;

  logic [7:0]  start_byte;
  logic [7:0]  end_byte;

  phase_t      phase, phase_next;
  logic [1:0]  field_index, field_index_next;
  logic        tag_mismatch, tag_mismatch_next;
  logic [7:0]  mode_value, mode_value_next;
  logic [31:0] declared_length, declared_length_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;

  res_t        res_reg;
  res_t        skid;
  logic        skid_valid;
  res_t        res_new;
  logic        res_fire;

  logic        rx_fire;
  logic        res_take;
  logic [31:0] len_acc;
  logic [31:0] rem_dec;
  logic        bad;
  logic [1:0]  start_idx;
  logic        start_mis;

  assign rx_stall = skid_valid;
  assign rx_fire  = rx_valid & ~skid_valid;
  assign res_take = res_valid & ~res_stall;

  assign kind          = res_reg.kind;
  assign data_byte     = res_reg.data_byte;
  assign frame_mode    = res_reg.frame_mode;
  assign packet_length = res_reg.packet_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
      end_byte   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE: start_byte <= cfg_data;
        REG_END_BYTE:   end_byte   <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_comb begin
    phase_next           = phase;
    field_index_next     = field_index;
    tag_mismatch_next    = tag_mismatch;
    mode_value_next      = mode_value;
    declared_length_next = declared_length;
    bytes_remaining_next = bytes_remaining;
    res_fire             = 1'b0;
    res_new              = '{kind: KIND_DATA, data_byte: 8'd0,
                             frame_mode: mode_value, packet_length: declared_length};
    len_acc   = declared_length | (32'(rx_byte) << {field_index, 3'b000});
    rem_dec   = bytes_remaining - 32'd1;
    bad       = 1'b0;
    start_idx = (phase == PH_START) ? field_index : 2'd0;
    start_mis = (phase == PH_START) ? tag_mismatch : 1'b0;
    if (rx_fire) begin
      case (phase)
        PH_MODE: begin
          mode_value_next      = rx_byte;
          declared_length_next = '0;
          field_index_next     = '0;
          phase_next           = PH_LENGTH;
        end
        PH_LENGTH: begin
          declared_length_next = len_acc;
          if (field_index == LENGTH_LAST) begin
            field_index_next     = '0;
            tag_mismatch_next    = 1'b0;
            bytes_remaining_next = len_acc;
            phase_next           = (len_acc == 32'd0) ? PH_END : PH_DATA;
          end else begin
            field_index_next = field_index + 2'd1;
          end
        end
        PH_DATA: begin
          res_fire             = 1'b1;
          res_new.data_byte    = rx_byte;
          bytes_remaining_next = rem_dec;
          if (rem_dec == 32'd0) begin
            field_index_next  = '0;
            tag_mismatch_next = 1'b0;
            phase_next        = PH_END;
          end
        end
        PH_END: begin
          bad = tag_mismatch | (rx_byte != end_byte);
          if (field_index == END_LAST) begin
            res_fire          = 1'b1;
            res_new.kind      = bad ? KIND_DROP : KIND_ACCEPT;
            phase_next        = PH_START;
            field_index_next  = '0;
            tag_mismatch_next = 1'b0;
          end else begin
            tag_mismatch_next = bad;
            field_index_next  = field_index + 2'd1;
          end
        end
        default: begin
          bad = start_mis | (rx_byte != start_byte);
          if (start_idx == START_LAST) begin
            field_index_next  = '0;
            tag_mismatch_next = 1'b0;
            phase_next        = bad ? PH_START : PH_MODE;
          end else begin
            phase_next        = PH_START;
            tag_mismatch_next = bad;
            field_index_next  = start_idx + 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      field_index     <= '0;
      tag_mismatch    <= 1'b0;
      mode_value      <= '0;
      declared_length <= '0;
      bytes_remaining <= '0;
    end else begin
      phase           <= phase_next;
      field_index     <= field_index_next;
      tag_mismatch    <= tag_mismatch_next;
      mode_value      <= mode_value_next;
      declared_length <= declared_length_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_take) begin
        res_reg    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (res_fire) begin
      if (!res_valid || res_take) begin
        res_reg   <= res_new;
        res_valid <= 1'b1;
      end else begin
        skid       <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dpd_checker.sv
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level checks on result beats, bound to the deframer top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "delimited_packet_deframer_defines.svh"

module dpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_valid,
  input wire logic        rx_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  data_byte,
  input wire logic [7:0]  frame_mode,
  input wire logic [31:0] packet_length
);

  import dpd_pkg::*;

  logic        rx_fire;
  logic        kind_ok;
  logic [49:0] res_word;

  assign rx_fire  = rx_valid & ~rx_stall;
  assign kind_ok  = (kind == KIND_DATA) | (kind == KIND_ACCEPT) | (kind == KIND_DROP);
  assign res_word = {kind, data_byte, frame_mode, packet_length};

  `DPD_ASSERT_NOW(a_kind_legal, clk, rst, res_valid, kind_ok)
  `DPD_ASSERT_NOW(a_data_zero, clk, rst, res_valid && kind != KIND_DATA, data_byte == 8'd0)
  `DPD_ASSERT_NEXT(a_no_spurious, clk, rst, !res_valid && !rx_fire, !res_valid)
  `DPD_ASSERT_NEXT(a_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res_word))

endmodule

bind delimited_packet_deframer dpd_checker u_dpd_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Delimited packet deframer testbench
// Feeds byte streams of framed packets, broken frames and noise through the
// deframer while both handshakes idle at random. A predictor tracks the parse
// state and queues the payload, accept and drop beats it expects, and a
// checker compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1850;
  localparam int SEGMENTS     = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_START_BYTE;
  logic [7:0]  cfg_data = 8'h00;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  frame_mode;
  logic [31:0] packet_length;

  logic [7:0]  start_tag_byte;
  logic [7:0]  end_tag_byte;
  phase_t      parse_phase;
  logic [1:0]  field_pos;
  logic        tag_bad;
  logic [7:0]  cur_mode;
  logic [31:0] cur_length;
  logic [31:0] left_bytes;
  res_t        due_beats[$];

  int          sent_bytes = 0;
  int          errors = 0;
  int          payload_beats = 0;
  int          accepted_pkts = 0;
  int          dropped_pkts = 0;
  bit          rx_idle_on = 1'b0;
  bit          res_idle_on = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;

  delimited_packet_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .frame_mode    (frame_mode),
    .packet_length (packet_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic void restart_search();
    parse_phase = PH_START;
    field_pos   = 2'd0;
    tag_bad     = 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic bad;
    sent_bytes++;
    case (parse_phase)
      PH_MODE: begin
        cur_mode    = b;
        cur_length  = 32'd0;
        field_pos   = 2'd0;
        parse_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        cur_length = cur_length | (32'(b) << (8 * field_pos));
        if (field_pos == LENGTH_LAST) begin
          field_pos   = 2'd0;
          tag_bad     = 1'b0;
          left_bytes  = cur_length;
          parse_phase = (cur_length == 32'd0) ? PH_END : PH_DATA;
        end else begin
          field_pos = field_pos + 2'd1;
        end
      end
      PH_DATA: begin
        due_beats.push_back('{KIND_DATA, b, cur_mode, cur_length});
        left_bytes = left_bytes - 32'd1;
        if (left_bytes == 32'd0) begin
          field_pos   = 2'd0;
          tag_bad     = 1'b0;
          parse_phase = PH_END;
        end
      end
      PH_END: begin
        bad = tag_bad || (b != end_tag_byte);
        if (field_pos == END_LAST) begin
          due_beats.push_back('{bad ? KIND_DROP : KIND_ACCEPT, 8'h00, cur_mode, cur_length});
          restart_search();
        end else begin
          tag_bad   = bad;
          field_pos = field_pos + 2'd1;
        end
      end
      default: begin
        bad = tag_bad || (b != start_tag_byte);
        if (field_pos == START_LAST) begin
          if (bad) begin
            restart_search();
          end else begin
            field_pos   = 2'd0;
            tag_bad     = 1'b0;
            parse_phase = PH_MODE;
          end
        end else begin
          tag_bad   = bad;
          field_pos = field_pos + 2'd1;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    int unsigned n;
    res_t want;
    if (rst) begin
      res_stall   <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (due_beats.size() == 0) begin
          $error("unexpected beat: kind %0d data_byte %h", kind, data_byte);
          errors++;
        end else begin
          want = due_beats.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            errors++;
          end
          if (data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, got %h", want.data_byte, data_byte);
            errors++;
          end
          if (frame_mode !== want.frame_mode) begin
            $error("frame_mode: expected %h, got %h", want.frame_mode, frame_mode);
            errors++;
          end
          if (packet_length !== want.packet_length) begin
            $error("packet_length: expected %h, got %h", want.packet_length,
                   packet_length);
            errors++;
          end
          case (want.kind)
            KIND_DATA:   payload_beats++;
            KIND_ACCEPT: accepted_pkts++;
            default:     dropped_pkts++;
          endcase
        end
        n = res_idle_on ? $urandom_range(0, 3) : 0;
        hold_cycles <= n;
        res_stall   <= (n != 0);
      end else if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        res_stall   <= (hold_cycles > 1);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = rx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    deframe_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] mode, input logic [31:0] length,
                            input int body, input int tail, input logic [31:0] end_tag);
    repeat (START_TAG_LEN) send_byte(start_tag_byte);
    send_byte(mode);
    for (int i = 0; i < LENGTH_BYTES; i++) send_byte(length[8*i +: 8]);
    repeat (body) send_byte(8'($urandom));
    for (int i = 0; i < tail; i++) send_byte(end_tag[8*i +: 8]);
  endtask

  // drain the result queue, then let the output register settle
  task automatic settle();
    rx_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic resync();
    while (!(parse_phase == PH_START && field_pos == 2'd0)) send_byte(8'($urandom));
  endtask

  task automatic write_tags(input logic [7:0] start_val, input logic [7:0] end_val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_data  <= start_val;
    @(posedge clk);
    start_tag_byte = start_val;
    cfg_index <= REG_END_BYTE;
    cfg_data  <= end_val;
    @(posedge clk);
    end_tag_byte = end_val;
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    int pick;
    int sel;
    int body;
    int pos;
    logic [7:0] flip;
    logic [31:0] tag;
    rx_idle_on  = ($urandom_range(0, 4) != 0);
    res_idle_on = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 9) != 0) resync();
    sel = $urandom_range(0, 99);
    if (sel < 70) body = $urandom_range(0, 8);
    else if (sel < 95) body = $urandom_range(9, 40);
    else body = $urandom_range(41, 200);
    pick = $urandom_range(0, 99);
    pos  = $urandom_range(0, 3);
    flip = 8'($urandom_range(1, 255));
    tag  = {4{end_tag_byte}};
    if (pick < 70) begin
      send_frame(8'($urandom), 32'(body), body, END_TAG_LEN, tag);
    end else if (pick < 80) begin
      send_frame(8'($urandom), 32'(body), body, END_TAG_LEN, tag ^ (32'(flip) << (8 * pos)));
    end else if (pick < 88) begin
      for (int i = 0; i < START_TAG_LEN; i++)
        send_byte((i == pos) ? (start_tag_byte ^ flip) : start_tag_byte);
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      // truncated: declared length runs past the bytes that follow
      send_frame(8'($urandom), 32'(body + 2), body, 0, tag);
    end
  endtask

  task automatic test_zero_length();
    rx_idle_on  = 1'b1;
    res_idle_on = 1'b1;
    send_frame(8'hFF, 32'd0, 0, END_TAG_LEN, {4{end_tag_byte}});
    settle();
  endtask

  task automatic test_bad_start_group();
    write_tags(8'hFF, 8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 32'd1, 1, END_TAG_LEN, 32'h00FF_0000);
    settle();
  endtask

  task automatic test_random_frames();
    int goal;
    logic [7:0] s;
    logic [7:0] e;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin s = 8'h00; e = 8'hFF; end
        1: begin s = 8'hFF; e = 8'h00; end
        2: begin s = 8'h5A; e = 8'h5A; end
        default: begin s = 8'($urandom); e = 8'($urandom); end
      endcase
      write_tags(s, e);
      goal = sent_bytes + RANDOM_BYTES / SEGMENTS;
      while (sent_bytes < goal) random_frame();
      settle();
    end
  endtask

  // leaves the parser in the payload phase, so it runs last
  task automatic test_long_length();
    rx_idle_on  = 1'b1;
    res_idle_on = 1'b1;
    resync();
    write_tags(8'($urandom), 8'($urandom));
    send_frame(8'h81, 32'hFFFF_FFFF, 6, 0, 32'd0);
    settle();
  endtask

  initial begin
    start_tag_byte = 8'h00;
    end_tag_byte   = 8'h00;
    restart_search();
    cur_mode   = 8'h00;
    cur_length = 32'd0;
    left_bytes = 32'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_zero_length();
    test_bad_start_group();
    test_random_frames();
    test_long_length();
    $display("Checked %0d payload beats, %0d accepted and %0d dropped packets",
             payload_beats, accepted_pkts, dropped_pkts);
    $display("from %0d input bytes under %0d tag settings", sent_bytes, SEGMENTS + 3);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/dpd_pkg.sv
hdl/delimited_packet_deframer.sv
hdl/dpd_checker.sv
tb/tb_top.sv
